FILE: src/scba_pkg.sv
`timescale 1ns / 1ps

package scba_pkg;

    localparam int CFG_CLASSES = 4;
    localparam int SLOT_LIMIT  = 64;

    localparam int SIZE_W   = 16;
    localparam int COUNT_W  = 7;
    localparam int CLASS_W  = 2;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED  = 2'd0,
        ST_NONE       = 2'd1,
        ST_FREED      = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_SIZE0  = 3'd0,
        REG_SIZE1  = 3'd1,
        REG_SIZE2  = 3'd2,
        REG_SIZE3  = 3'd3,
        REG_COUNT0 = 3'd4,
        REG_COUNT1 = 3'd5,
        REG_COUNT2 = 3'd6,
        REG_COUNT3 = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_CLASSES-1:0][SIZE_W-1:0]  size;
        logic [CFG_CLASSES-1:0][COUNT_W-1:0] count;
    } cfg_t;

    typedef struct packed {
        logic              action;
        logic [SIZE_W-1:0] req_size;
        logic [CLASS_W-1:0] free_class;
        logic [SLOT_W-1:0] free_slot;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [CLASS_W-1:0] grant_class;
        logic [SLOT_W-1:0]  grant_slot;
    } res_t;

endpackage

FILE: src/size_class_block_allocator_core.sv
`timescale 1ns / 1ps

// Fixed-size block pool allocator. One request is taken per clock unless the input stalls
// (full result register, m_ready low); one result item is returned per request, in order,
// via the input register, then the result register. The rate is set by the combinational
// decision path between them: per-class size compare and lowest-free-slot search over the
// used bitmaps, first-match class select, and the used-map update written at the same edge
// as the result, so the next request already sees it. Used maps clear at reset; the user
// must write block sizes and counts over the APB port while the block is idle (unchecked).
module size_class_block_allocator_core #(
    parameter int NUM_CLASSES = 4,
    parameter int MAX_BLOCKS  = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [scba_pkg::SIZE_W-1:0]   s_req_size,
    input  logic [scba_pkg::CLASS_W-1:0]  s_free_class,
    input  logic [scba_pkg::SLOT_W-1:0]   s_free_slot,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [scba_pkg::STATUS_W-1:0] m_status,
    output logic [scba_pkg::CLASS_W-1:0]  m_grant_class,
    output logic [scba_pkg::SLOT_W-1:0]   m_grant_slot,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scba_pkg::ADDR_W-1:0]   paddr,
    input  logic [scba_pkg::DATA_W-1:0]   pwdata,
    output logic [scba_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import scba_pkg::*;

    cfg_t cfg;
    req_t req_reg;
    res_t res_reg;
    res_t res_next;
    logic in_valid_reg;
    logic out_valid_reg;
    logic fire;

    scba_cfg_regs #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_cfg (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg_o  (cfg)
    );

    scba_alloc_core #(
        .NUM_CLASSES(NUM_CLASSES),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_i   (cfg),
        .req_i   (req_reg),
        .update_i(fire),
        .res_o   (res_next)
    );

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= '{action: s_action, req_size: s_req_size,
                         free_class: s_free_class, free_slot: s_free_slot};
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = res_reg.status;
    assign m_grant_class = res_reg.grant_class;
    assign m_grant_slot  = res_reg.grant_slot;

    a_stall_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while result path free");

    a_no_grant_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_ALLOCATED)) |-> ((m_grant_class == '0) && (m_grant_slot == '0)))
        else $error("grant fields set on a result that is not a grant");

    a_result_from_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result item raised without a held request");

endmodule

FILE: src/scba_cfg_regs.sv
`timescale 1ns / 1ps

module scba_cfg_regs #(
    parameter int NUM_CLASSES = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scba_pkg::ADDR_W-1:0]   paddr,
    input  logic [scba_pkg::DATA_W-1:0]   pwdata,
    output logic [scba_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output scba_pkg::cfg_t                cfg_o
);
    import scba_pkg::*;

    localparam int LIVE = (NUM_CLASSES < CFG_CLASSES) ? NUM_CLASSES : CFG_CLASSES;

    logic [SIZE_W-1:0]  size_reg  [LIVE];
    logic [COUNT_W-1:0] count_reg [LIVE];

    reg_idx_t           reg_idx;
    logic               is_count;
    logic [CLASS_W-1:0] cls;
    logic               wr_en;

    assign reg_idx  = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign is_count = (reg_idx >= REG_COUNT0);
    assign cls      = CLASS_W'(reg_idx);
    assign wr_en    = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < LIVE; c++) begin
                size_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
        end else if (wr_en) begin
            for (int c = 0; c < LIVE; c++) begin
                if (cls == CLASS_W'(c)) begin
                    if (is_count) begin
                        count_reg[c] <= pwdata[COUNT_W-1:0];
                    end else begin
                        size_reg[c] <= pwdata[SIZE_W-1:0];
                    end
                end
            end
        end
    end

    always_comb begin
        cfg_o = '0;
        for (int c = 0; c < LIVE; c++) begin
            cfg_o.size[c]  = size_reg[c];
            cfg_o.count[c] = count_reg[c];
        end
    end

    always_comb begin
        if (is_count) begin
            prdata = DATA_W'(cfg_o.count[cls]);
        end else begin
            prdata = DATA_W'(cfg_o.size[cls]);
        end
    end

endmodule

FILE: src/scba_alloc_core.sv
`timescale 1ns / 1ps

module scba_alloc_core #(
    parameter int NUM_CLASSES = 4,
    parameter int MAX_BLOCKS  = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  scba_pkg::cfg_t  cfg_i,
    input  scba_pkg::req_t  req_i,
    input  logic            update_i,
    output scba_pkg::res_t  res_o
);
    import scba_pkg::*;

    localparam int LIVE  = (NUM_CLASSES < CFG_CLASSES) ? NUM_CLASSES : CFG_CLASSES;
    localparam int SLOTS = (MAX_BLOCKS < SLOT_LIMIT) ? MAX_BLOCKS : SLOT_LIMIT;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0] used_reg  [LIVE];
    logic [SLOTS-1:0] used_next [LIVE];

    logic [CNT_W-1:0] eff      [CFG_CLASSES];
    logic [SLOTS-1:0] mask     [LIVE];
    logic [SLOTS-1:0] free_bits[LIVE];
    logic [SLOTS-1:0] lowest   [LIVE];
    logic [IDX_W-1:0] idx      [LIVE];
    logic [LIVE-1:0]  hit;

    logic               found;
    logic [CLASS_W-1:0] win_cls;
    logic [IDX_W-1:0]   win_idx;
    logic               is_alloc;
    logic               free_ok;

    // effective counts, clamped to the slot capacity
    always_comb begin
        for (int c = 0; c < CFG_CLASSES; c++) begin
            if (cfg_i.count[c] > COUNT_W'(SLOTS)) begin
                eff[c] = CNT_W'(SLOTS);
            end else begin
                eff[c] = CNT_W'(cfg_i.count[c]);
            end
        end
    end

    // one lane per class: size match and lowest free slot
    always_comb begin
        for (int c = 0; c < LIVE; c++) begin
            for (int s = 0; s < SLOTS; s++) begin
                mask[c][s] = (CNT_W'(s) < eff[c]);
            end
            free_bits[c] = ~used_reg[c] & mask[c];
            lowest[c]    = free_bits[c] & (~free_bits[c] + 1'b1);
            hit[c]       = (cfg_i.size[c] == req_i.req_size) && (|free_bits[c]);
            idx[c]       = '0;
            for (int s = 0; s < SLOTS; s++) begin
                if (lowest[c][s]) begin
                    idx[c] = idx[c] | IDX_W'(s);
                end
            end
        end
    end

    // first matching class wins
    always_comb begin
        found   = 1'b0;
        win_cls = '0;
        win_idx = '0;
        for (int c = 0; c < LIVE; c++) begin
            if (!found && hit[c]) begin
                found   = 1'b1;
                win_cls = CLASS_W'(c);
                win_idx = idx[c];
            end
        end
    end

    assign is_alloc = (req_i.action == ACT_ALLOC);
    assign free_ok  = ({1'b0, req_i.free_slot} < COUNT_W'(eff[req_i.free_class]));

    always_comb begin
        res_o = '{status: ST_NONE, grant_class: '0, grant_slot: '0};
        if (is_alloc) begin
            if (found) begin
                res_o.status      = ST_ALLOCATED;
                res_o.grant_class = win_cls;
                res_o.grant_slot  = SLOT_W'(win_idx);
            end
        end else if (free_ok) begin
            res_o.status = ST_FREED;
        end else begin
            res_o.status = ST_BAD_HANDLE;
        end
    end

    always_comb begin
        for (int c = 0; c < LIVE; c++) begin
            used_next[c] = used_reg[c];
            if (update_i) begin
                if (is_alloc && found && (win_cls == CLASS_W'(c))) begin
                    used_next[c] = used_reg[c] | lowest[c];
                end
                if (!is_alloc && free_ok && (req_i.free_class == CLASS_W'(c))) begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (req_i.free_slot == SLOT_W'(s)) begin
                            used_next[c][s] = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < LIVE; c++) begin
                used_reg[c] <= '0;
            end
        end else begin
            for (int c = 0; c < LIVE; c++) begin
                used_reg[c] <= used_next[c];
            end
        end
    end

endmodule
